// ----- rtl/pfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants for the Playfair encryptor
// Letter codes, operation codes, sequencer states, the store write beat and
// the grid position helpers (row and column of a cell).
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int GRID_CELLS = 25;
   localparam int ALPHABET   = 26;

   localparam logic [4:0] LET_I = 5'd8;
   localparam logic [4:0] LET_J = 5'd9;
   localparam logic [4:0] LET_X = 5'd23;
   localparam logic [4:0] LET_Z = 5'd25;
   localparam logic [4:0] LAST_CELL = 5'(GRID_CELLS - 1);
   localparam logic [4:0] LAST_LETTER = 5'(ALPHABET - 1);

   typedef enum logic [1:0] {
      OP_KEY      = 2'd0,
      OP_KEY_END  = 2'd1,
      OP_TEXT     = 2'd2,
      OP_TEXT_END = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_POS,
      ST_GRID,
      ST_SEND0,
      ST_SEND1,
      ST_NONE
   } state_type;

   // One write into both grid stores: slot holds letter, letter sits at slot
   typedef struct packed {
      logic       en;
      logic [4:0] slot;
      logic [4:0] letter;
   } store_wr_type;

   // Row of a cell 0..24: multiply by the reciprocal of five
   function automatic logic [2:0] pos_row(input logic [4:0] p);
      logic [9:0] prod;
      prod = 10'(p) * 10'd13;
      return prod[8:6];
   endfunction

   // Column of a cell 0..24
   function automatic logic [2:0] pos_col(input logic [4:0] p);
      logic [4:0] base;
      base = 5'(pos_row(p)) * 5'd5;
      return 3'(p - base);
   endfunction

   // Filler letter for a doubled or odd letter
   function automatic logic [4:0] filler_for(input logic [4:0] l);
      return (l == LET_X) ? LET_Z : LET_X;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/playfair_cipher_encrypt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt: Playfair encryption of a letter stream
// Builds the 5x5 key grid from key letters, then pairs plaintext letters
// into digraphs and returns two cipher letters per digraph.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat fields
//  req_*    in   tuser[1:0] operation, tdata[4:0] letter
//  rsp_*    out  tdata[4:0] cipher_letter, tuser[0] second_of_pair,
//                tuser[1] no_letter, tlast message_end
//
//  Key letters and plaintext letters that only open a digraph are taken in
//  the idle state, which stays ready for the next beat. A closed digraph
//  passes through accept, position read, grid read, then one beat per cipher
//  letter; the first result beat waits on the two memory reads in series.
//  A key end walks the alphabet through the shared write port.
//  The input is not ready while a digraph or the fill is in flight; result
//  beats hold while rsp_tready is low. Reset clears the sequencer, the
//  present mask, the fill count and the pending letter; grid memories are
//  valid only once written.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [4:0] letter, [7:5] zero
   input  wire  [1:0] req_tuser,   // [1:0] operation
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [4:0] cipher_letter, [7:5] zero
   output logic [1:0] rsp_tuser,   // [0] second_of_pair, [1] no_letter
   output logic       rsp_tlast    // message_end
);

   pfe_pkg::state_type    state_ff, state_in;
   logic [25:0]           present_ff, present_in;
   logic [4:0]            count_ff, count_in;
   logic                  complete_ff, complete_in;
   logic [4:0]            pending_ff, pending_in;
   logic                  pending_valid_ff, pending_valid_in;
   logic [4:0]            fill_idx_ff, fill_idx_in;
   logic [4:0]            let_a_ff, let_a_in;
   logic [4:0]            let_b_ff, let_b_in;
   logic                  end_ff, end_in;

   pfe_pkg::store_wr_type wr;
   logic                  pos_rd_en, grid_rd_en;
   logic [4:0]            pos_q_a, pos_q_b;
   logic [4:0]            cell_a, cell_b;
   logic [4:0]            grid_q_a, grid_q_b;

   pfe_pkg::op_type       op;
   logic [4:0]            letter_raw, letter;
   logic                  letter_ok;
   logic                  req_fire, rsp_fire;
   logic [4:0]            place_letter;
   logic                  place_try;

   assign op         = pfe_pkg::op_type'(req_tuser);
   assign letter_raw = req_tdata[4:0];
   assign letter_ok  = (letter_raw <= pfe_pkg::LAST_LETTER);
   assign letter     = (letter_raw == pfe_pkg::LET_J) ? pfe_pkg::LET_I : letter_raw;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Shared write port into the grid stores
   always_comb begin
      wr.en     = 1'b0;
      wr.slot   = count_ff;
      wr.letter = place_letter;
      if (place_try && !present_ff[place_letter] && !complete_ff
          && count_ff <= pfe_pkg::LAST_CELL) begin
         wr.en = 1'b1;
      end
   end

   pfe_store u_store (
      .clock       (clock),
      .wr          (wr),
      .pos_rd_en   (pos_rd_en),
      .pos_addr_a  (let_a_ff),
      .pos_addr_b  (let_b_ff),
      .pos_q_a     (pos_q_a),
      .pos_q_b     (pos_q_b),
      .grid_rd_en  (grid_rd_en),
      .grid_addr_a (cell_a),
      .grid_addr_b (cell_b),
      .grid_q_a    (grid_q_a),
      .grid_q_b    (grid_q_b)
   );

   pfe_rule u_rule (
      .pos_a  (pos_q_a),
      .pos_b  (pos_q_b),
      .cell_a (cell_a),
      .cell_b (cell_b)
   );

   // Hold state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pfe_pkg::ST_IDLE;
         present_ff       <= '0;
         count_ff         <= '0;
         complete_ff      <= 1'b0;
         pending_ff       <= '0;
         pending_valid_ff <= 1'b0;
         fill_idx_ff      <= '0;
         end_ff           <= 1'b0;
      end else begin
         state_ff         <= state_in;
         present_ff       <= present_in;
         count_ff         <= count_in;
         complete_ff      <= complete_in;
         pending_ff       <= pending_in;
         pending_valid_ff <= pending_valid_in;
         fill_idx_ff      <= fill_idx_in;
         end_ff           <= end_in;
      end
   end

   // Hold digraph letters
   always_ff @(posedge clock) begin
      let_a_ff <= let_a_in;
      let_b_ff <= let_b_in;
   end

   // Sequence the block: next state and outputs
   always_comb begin
      state_in         = state_ff;
      present_in       = present_ff;
      count_in         = count_ff;
      complete_in      = complete_ff;
      pending_in       = pending_ff;
      pending_valid_in = pending_valid_ff;
      fill_idx_in      = fill_idx_ff;
      let_a_in         = let_a_ff;
      let_b_in         = let_b_ff;
      end_in           = end_ff;
      place_letter     = letter;
      place_try        = 1'b0;
      pos_rd_en        = 1'b0;
      grid_rd_en       = 1'b0;
      req_tready       = 1'b0;
      rsp_tvalid       = 1'b0;
      rsp_tdata        = '0;
      rsp_tuser        = '0;
      rsp_tlast        = 1'b0;

      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               case (op)
                  pfe_pkg::OP_KEY: begin
                     place_try = letter_ok;
                  end
                  pfe_pkg::OP_KEY_END: begin
                     if (!complete_ff) begin
                        fill_idx_in = '0;
                        state_in    = pfe_pkg::ST_FILL;
                     end
                  end
                  pfe_pkg::OP_TEXT: begin
                     if (letter_ok && complete_ff) begin
                        if (!pending_valid_ff) begin
                           pending_in       = letter;
                           pending_valid_in = 1'b1;
                        end else begin
                           let_a_in = pending_ff;
                           end_in   = 1'b0;
                           state_in = pfe_pkg::ST_POS;
                           if (letter == pending_ff) begin
                              let_b_in = pfe_pkg::filler_for(pending_ff);
                           end else begin
                              let_b_in         = letter;
                              pending_valid_in = 1'b0;
                           end
                        end
                     end
                  end
                  pfe_pkg::OP_TEXT_END: begin
                     if (complete_ff) begin
                        if (pending_valid_ff) begin
                           let_a_in         = pending_ff;
                           let_b_in         = pfe_pkg::filler_for(pending_ff);
                           end_in           = 1'b1;
                           pending_valid_in = 1'b0;
                           state_in         = pfe_pkg::ST_POS;
                        end else begin
                           state_in = pfe_pkg::ST_NONE;
                        end
                     end
                  end
                  default: begin
                     state_in = pfe_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         // Walk the alphabet and place every unused letter but j
         pfe_pkg::ST_FILL: begin
            place_letter = fill_idx_ff;
            place_try    = (fill_idx_ff != pfe_pkg::LET_J);
            fill_idx_in  = fill_idx_ff + 5'd1;
            if (fill_idx_ff == pfe_pkg::LAST_LETTER) begin
               complete_in = 1'b1;
               state_in    = pfe_pkg::ST_IDLE;
            end
         end

         // Read both letter positions
         pfe_pkg::ST_POS: begin
            pos_rd_en = 1'b1;
            state_in  = pfe_pkg::ST_GRID;
         end

         // Map cells and read both cipher letters
         pfe_pkg::ST_GRID: begin
            grid_rd_en = 1'b1;
            state_in   = pfe_pkg::ST_SEND0;
         end

         pfe_pkg::ST_SEND0: begin
            rsp_tvalid     = 1'b1;
            rsp_tdata[4:0] = grid_q_a;
            if (rsp_fire) begin
               state_in = pfe_pkg::ST_SEND1;
            end
         end

         pfe_pkg::ST_SEND1: begin
            rsp_tvalid     = 1'b1;
            rsp_tdata[4:0] = grid_q_b;
            rsp_tuser[0]   = 1'b1;
            rsp_tlast      = end_ff;
            if (rsp_fire) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end

         // Plaintext end with nothing pending
         pfe_pkg::ST_NONE: begin
            rsp_tvalid   = 1'b1;
            rsp_tuser[1] = 1'b1;
            rsp_tlast    = 1'b1;
            if (rsp_fire) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase

      // Advance the fill on each placed letter
      if (wr.en) begin
         present_in[wr.letter] = 1'b1;
         count_in              = count_ff + 5'd1;
         if (count_ff == pfe_pkg::LAST_CELL) begin
            complete_in = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/pfe_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_store: key grid and letter position memories
// One shared write port fills both tables; each table has two registered
// read ports, used for the two letters of a digraph.
// ----------------------------------------------------------------------------
module pfe_store (
   input  wire                        clock,
   input  wire pfe_pkg::store_wr_type wr,
   input  wire                        pos_rd_en,
   input  wire  [4:0]                 pos_addr_a,
   input  wire  [4:0]                 pos_addr_b,
   output logic [4:0]                 pos_q_a,
   output logic [4:0]                 pos_q_b,
   input  wire                        grid_rd_en,
   input  wire  [4:0]                 grid_addr_a,
   input  wire  [4:0]                 grid_addr_b,
   output logic [4:0]                 grid_q_a,
   output logic [4:0]                 grid_q_b
);

   logic [4:0] grid_mem [pfe_pkg::GRID_CELLS];
   logic [4:0] pos_mem  [pfe_pkg::ALPHABET];

   // Write both tables
   always_ff @(posedge clock) begin
      if (wr.en) begin
         grid_mem[wr.slot]  <= wr.letter;
         pos_mem[wr.letter] <= wr.slot;
      end
   end

   // Register position reads
   always_ff @(posedge clock) begin
      if (pos_rd_en) begin
         pos_q_a <= pos_mem[pos_addr_a];
         pos_q_b <= pos_mem[pos_addr_b];
      end
   end

   // Register grid reads
   always_ff @(posedge clock) begin
      if (grid_rd_en) begin
         grid_q_a <= grid_mem[grid_addr_a];
         grid_q_b <= grid_mem[grid_addr_b];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/pfe_rule.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfe_rule: digraph cell mapping
// Maps the cells of two letters to the cells of their cipher letters by the
// row, column or rectangle rule.
// ----------------------------------------------------------------------------
module pfe_rule (
   input  wire  [4:0] pos_a,
   input  wire  [4:0] pos_b,
   output logic [4:0] cell_a,
   output logic [4:0] cell_b
);

   logic [2:0] r1, c1, r2, c2;
   logic [2:0] r1_out, c1_out, r2_out, c2_out;

   // Split cells into row and column
   always_comb begin
      r1 = pfe_pkg::pos_row(pos_a);
      c1 = pfe_pkg::pos_col(pos_a);
      r2 = pfe_pkg::pos_row(pos_b);
      c2 = pfe_pkg::pos_col(pos_b);
   end

   // Pick the rule: same row shifts right, same column shifts down,
   // otherwise swap the rectangle corners
   always_comb begin
      r1_out = r1;
      r2_out = r2;
      c1_out = c2;
      c2_out = c1;
      if (r1 == r2) begin
         c1_out = (c1 == 3'd4) ? 3'd0 : c1 + 3'd1;
         c2_out = (c2 == 3'd4) ? 3'd0 : c2 + 3'd1;
      end else if (c1 == c2) begin
         r1_out = (r1 == 3'd4) ? 3'd0 : r1 + 3'd1;
         r2_out = (r2 == 3'd4) ? 3'd0 : r2 + 3'd1;
         c1_out = c1;
         c2_out = c2;
      end
      cell_a = 5'(r1_out) * 5'd5 + 5'(c1_out);
      cell_b = 5'(r2_out) * 5'd5 + 5'(c2_out);
   end

endmodule
`default_nettype wire

// ----- test/playfair_cipher_encrypt_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt_test: self-checking bench for the Playfair encryptor
// Builds one key grid after reset, then streams plaintext beats and checks
// every cipher beat against an in-bench digraph predictor. A short directed
// table covers the corner cases and is followed by randomized traffic, with
// random idling on both channels, a receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TEXT_BEATS   = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int SHOW_LIMIT   = 10;

   // How a directed row is checked
   typedef enum logic [1:0] {
      CHK_PREDICT,   // expectations come from the predictor
      CHK_NONE,      // row gives no cipher beat
      CHK_BLANK      // message end with nothing open: one blank beat
   } row_check_type;

   typedef struct {
      pfe_pkg::op_type op;
      logic [4:0]      letter;
      row_check_type   check;
   } plan_row_type;

   typedef struct packed {
      logic [4:0] letter;
      logic       second;
      logic       msg_end;
      logic       none;
   } cipher_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   wire        req_tready;
   logic [7:0] req_tdata = 8'd0;    // [4:0] letter, [7:5] zero
   logic [1:0] req_tuser = 2'd0;    // [1:0] operation
   wire        rsp_tvalid;
   logic       rsp_tready = 1'b0;
   wire  [7:0] rsp_tdata;           // [4:0] cipher_letter, [7:5] zero
   wire  [1:0] rsp_tuser;           // [0] second_of_pair, [1] no_letter
   wire        rsp_tlast;           // message_end

   playfair_cipher_encrypt uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Predictor state: grid, letter positions and the open digraph
   logic [4:0]  grid_letter [pfe_pkg::GRID_CELLS];
   logic [4:0]  grid_cell [pfe_pkg::ALPHABET];
   logic [25:0] placed = '0;
   int          filled = 0;
   bit          grid_done = 1'b0;
   logic [4:0]  open_letter = '0;
   bit          open_valid = 1'b0;

   cipher_beat_type cipher_expect [$];

   bit idling = 1'b1;
   bit hold_request = 1'b0;
   bit key_by_letters;
   int errors = 0;
   int cycle_count = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int n_pairs = 0;
   int n_doubled = 0;
   int n_ends = 0;

   function automatic void place_key(input logic [4:0] l);
      if (filled >= pfe_pkg::GRID_CELLS || placed[l]) return;
      grid_letter[filled] = l;
      grid_cell[l] = 5'(filled);
      placed[l] = 1'b1;
      filled++;
      if (filled >= pfe_pkg::GRID_CELLS) grid_done = 1'b1;
   endfunction

   function automatic logic [4:0] pad_for(input logic [4:0] l);
      return (l == pfe_pkg::LET_X) ? pfe_pkg::LET_Z : pfe_pkg::LET_X;
   endfunction

   // Same row: shift right; same column: shift down; else swap the corners
   function automatic void encode_pair(input logic [4:0] a, input logic [4:0] b,
                                       input bit closes, input bit keep);
      int ra, ca, rb, cb, oa, ob;
      ra = int'(grid_cell[a]) / 5;
      ca = int'(grid_cell[a]) % 5;
      rb = int'(grid_cell[b]) / 5;
      cb = int'(grid_cell[b]) % 5;
      if (ra == rb) begin
         oa = ra * 5 + (ca + 1) % 5;
         ob = rb * 5 + (cb + 1) % 5;
      end else if (ca == cb) begin
         oa = ((ra + 1) % 5) * 5 + ca;
         ob = ((rb + 1) % 5) * 5 + cb;
      end else begin
         oa = ra * 5 + cb;
         ob = rb * 5 + ca;
      end
      n_pairs++;
      if (keep) begin
         cipher_expect.push_back('{grid_letter[oa], 1'b0, 1'b0, 1'b0});
         cipher_expect.push_back('{grid_letter[ob], 1'b1, closes, 1'b0});
      end
   endfunction

   // Advance the predictor by one accepted beat; queue results when keep is set
   function automatic void encrypt_beat(input pfe_pkg::op_type op,
                                        input logic [4:0] letter, input bit keep);
      logic [4:0] l;
      l = (letter == pfe_pkg::LET_J) ? pfe_pkg::LET_I : letter;
      case (op)
         pfe_pkg::OP_KEY: begin
            if (letter < pfe_pkg::ALPHABET && !grid_done) place_key(l);
         end
         pfe_pkg::OP_KEY_END: begin
            if (!grid_done) begin
               for (int k = 0; k < pfe_pkg::ALPHABET; k++)
                  if (k != pfe_pkg::LET_J) place_key(5'(k));
               grid_done = 1'b1;
            end
         end
         pfe_pkg::OP_TEXT: begin
            if (letter < pfe_pkg::ALPHABET && grid_done) begin
               if (!open_valid) begin
                  open_letter = l;
                  open_valid = 1'b1;
               end else if (l == open_letter) begin
                  // doubled letter: pad, and the letter opens the next digraph
                  n_doubled++;
                  encode_pair(open_letter, pad_for(open_letter), 1'b0, keep);
               end else begin
                  encode_pair(open_letter, l, 1'b0, keep);
                  open_valid = 1'b0;
               end
            end
         end
         default: begin
            if (grid_done) begin
               n_ends++;
               if (open_valid) begin
                  encode_pair(open_letter, pad_for(open_letter), 1'b1, keep);
                  open_valid = 1'b0;
               end else if (keep) begin
                  cipher_expect.push_back('{5'd0, 1'b0, 1'b1, 1'b1});
               end
            end
         end
      endcase
   endfunction

   // Offer one beat from a falling edge, hold it until accepted, then predict
   task automatic send_beat(input pfe_pkg::op_type op, input logic [4:0] letter,
                            input row_check_type check);
      if (idling && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (idling && $urandom_range(0, 99) < 27);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, letter};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      case (check)
         CHK_PREDICT: encrypt_beat(op, letter, 1'b1);
         CHK_NONE:    encrypt_beat(op, letter, 1'b0);
         default: begin
            encrypt_beat(op, letter, 1'b0);
            cipher_expect.push_back('{5'd0, 1'b0, 1'b1, 1'b1});
         end
      endcase
      @(negedge clock);
   endtask

   // Lower valid and wait for every outstanding cipher beat
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (cipher_expect.size() != 0);
   endtask

   // Run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when requested
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idling && $urandom_range(0, 99) < 27);
         end
      end
   end

   // Compare each accepted cipher beat with the oldest expectation
   always @(posedge clock) begin : check_rsp
      cipher_beat_type got;
      cipher_beat_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = '{rsp_tdata[4:0], rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
         if (cipher_expect.size() == 0) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("%0t unexpected cipher beat: letter %0d second %0b end %0b blank %0b",
                        $realtime, got.letter, got.second, got.msg_end, got.none);
         end else begin
            want = cipher_expect.pop_front();
            beats_checked++;
            if (got.letter !== want.letter || got.second !== want.second ||
                got.msg_end !== want.msg_end || got.none !== want.none) begin
               errors++;
               if (errors <= SHOW_LIMIT)
                  $display("%0t mismatch (letter/second/end/blank): expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                           $realtime, want.letter, want.second, want.msg_end, want.none,
                           got.letter, got.second, got.msg_end, got.none);
            end
         end
      end
   end

   initial begin : req_side
      plan_row_type    plan [$];
      logic [4:0]      unused [$];
      logic [4:0]      letter;
      pfe_pkg::op_type op;
      int              counted;
      int              pick;
      int              roll;
      bit              paused;
      bit              held;

      counted = 0;
      paused = 1'b0;
      held = 1'b0;
      // Half the seeds complete the grid with the 25th distinct key letter
      key_by_letters = 1'($urandom_range(0, 1));

      // Directed table
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd0,  CHK_NONE});     // plaintext before the grid
      plan.push_back('{pfe_pkg::OP_TEXT_END, 5'd0,  CHK_NONE});     // message end before the grid
      plan.push_back('{pfe_pkg::OP_KEY,      5'd25, CHK_NONE});     // z, highest letter
      plan.push_back('{pfe_pkg::OP_KEY,      5'd0,  CHK_NONE});     // a, lowest letter
      plan.push_back('{pfe_pkg::OP_KEY,      5'd9,  CHK_NONE});     // j folds to i
      plan.push_back('{pfe_pkg::OP_KEY,      5'd0,  CHK_NONE});     // repeat is skipped
      plan.push_back('{pfe_pkg::OP_KEY,      5'd31, CHK_NONE});     // code above z is dropped
      plan.push_back('{pfe_pkg::OP_KEY_END,  5'd0,  CHK_NONE});     // fill the rest of the grid
      plan.push_back('{pfe_pkg::OP_KEY,      5'd1,  CHK_NONE});     // key beat after completion
      plan.push_back('{pfe_pkg::OP_KEY_END,  5'd31, CHK_NONE});     // key end after completion
      plan.push_back('{pfe_pkg::OP_TEXT_END, 5'd0,  CHK_BLANK});    // end with nothing open
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd25, CHK_PREDICT});  // z c
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd2,  CHK_PREDICT});
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd0,  CHK_PREDICT});  // a u
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd20, CHK_PREDICT});
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd25, CHK_PREDICT});  // z u
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd20, CHK_PREDICT});
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd23, CHK_PREDICT});  // x x takes z as filler
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd23, CHK_PREDICT});
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd31, CHK_NONE});     // code above z is dropped
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd9,  CHK_PREDICT});  // j closes the open x
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd4,  CHK_PREDICT});  // e e takes x as filler
      plan.push_back('{pfe_pkg::OP_TEXT,     5'd4,  CHK_PREDICT});
      plan.push_back('{pfe_pkg::OP_TEXT_END, 5'd31, CHK_PREDICT});  // odd tail padded, message end

      // Hold reset, then release on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         if (plan[r].op == pfe_pkg::OP_KEY_END && key_by_letters && !grid_done) begin
            // Feed the missing letters in random order instead of a key end
            unused.delete();
            for (int k = 0; k < pfe_pkg::ALPHABET; k++)
               if (k != pfe_pkg::LET_J && !placed[k]) unused.push_back(5'(k));
            while (unused.size() != 0) begin
               pick = $urandom_range(0, unused.size() - 1);
               letter = unused[pick];
               unused.delete(pick);
               send_beat(pfe_pkg::OP_KEY, letter, CHK_PREDICT);
            end
         end
         send_beat(plan[r].op, plan[r].letter, plan[r].check);
      end

      // Random plaintext traffic
      while (counted < TEXT_BEATS) begin
         idling = !(counted >= 500 && counted < 900);
         if (counted >= 1000 && !paused) begin
            paused = 1'b1;
            drain_results();
         end
         if (counted >= 1100 && !held) begin
            held = 1'b1;
            hold_request = 1'b1;
         end
         roll = $urandom_range(0, 99);
         letter = 5'($urandom_range(0, 25));
         if (roll < 3) begin
            op = $urandom_range(0, 1) ? pfe_pkg::OP_KEY : pfe_pkg::OP_KEY_END;
            letter = 5'($urandom_range(0, 31));
         end else if (roll < 11) begin
            op = pfe_pkg::OP_TEXT_END;
            letter = 5'($urandom_range(0, 31));
            counted++;
         end else begin
            op = pfe_pkg::OP_TEXT;
            roll = $urandom_range(0, 99);
            if (open_valid && roll < 18)
               letter = (open_letter == pfe_pkg::LET_I && $urandom_range(0, 1))
                        ? pfe_pkg::LET_J : open_letter;
            else if (roll < 23)
               letter = 5'($urandom_range(26, 31));
            else if (roll < 33)
               letter = pfe_pkg::LET_X;
            if (letter < pfe_pkg::ALPHABET) counted++;
         end
         send_beat(op, letter, CHK_PREDICT);
      end

      idling = 1'b1;
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d input beats and %0d checked cipher beats: %0d digraphs,",
               beats_sent, beats_checked, n_pairs);
      $display("%0d doubled letters, %0d message ends; grid completed by %s.",
               n_doubled, n_ends, key_by_letters ? "the 25th key letter" : "a key end");
      if (errors == 0 && cipher_expect.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
